[design/grffa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the grid rectangle first-fit allocator.
// No dependencies.
package grffa_pkg;

   localparam int OP_W       = 3;
   localparam int POS_W      = 4;
   localparam int SIZE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_DATA_W-1:0] GRID_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 3'd0,
      OP_FIND  = 3'd1,
      OP_PLACE = 3'd2,
      OP_FREE  = 3'd3,
      OP_TEST  = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLS = 2'd0,
      CSR_GRID_ROWS = 2'd1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_MODIFY,
      ST_DONE
   } state_type;

endpackage

[design/grffa_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module grffa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/grid_rect_first_fit_allocator.sv]
`timescale 1ns / 1ps
// Grid rectangle first-fit allocator: occupancy bitmap with search, place, free, test.
// Depends on grffa_pkg and grffa_ram.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | opcode, pos_x, pos_y, size_x, size_y
//  rsp     | out       | rsp_valid/rsp_stall  | ok, found_x, found_y
//  csr     | in        | csr_valid/csr_ready  | index, wdata
//
// One request at a time; req_stall is high from acceptance until its result is loaded.
// Clear, failed bounds check or unused opcode: ST_START goes straight to ST_DONE, with no bitmap read.
// Place, free, test: read at most the size_y rows of the rectangle (place reads them once to scan, once to write).
// Find: scans candidate columns from x = 0 upward, each over all rows, one bitmap row read per cycle within a column.
// Synchronous reset empties the grid at once through per-row valid bits (no clearing pass).
// A stalled result sits in the output register; the next request is still taken.
module grid_rect_first_fit_allocator #(
   parameter int MAX_COLS = 16,
   parameter int MAX_ROWS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [grffa_pkg::OP_W-1:0]          req_opcode,
   input  logic [grffa_pkg::POS_W-1:0]         req_pos_x,
   input  logic [grffa_pkg::POS_W-1:0]         req_pos_y,
   input  logic [grffa_pkg::SIZE_W-1:0]        req_size_x,
   input  logic [grffa_pkg::SIZE_W-1:0]        req_size_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic [grffa_pkg::POS_W-1:0]         rsp_found_x,
   output logic [grffa_pkg::POS_W-1:0]         rsp_found_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [grffa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [grffa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CB     = $clog2(MAX_COLS + 1);
   localparam int RB     = $clog2(MAX_ROWS + 1);
   localparam int DB0    = (CB > RB) ? CB : RB;
   localparam int DW     = ((DB0 > grffa_pkg::SIZE_W) ? DB0 : grffa_pkg::SIZE_W) + 1;
   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int MW     = MAX_COLS + 48;
   localparam int SW     = grffa_pkg::SIZE_W;
   localparam int PW     = grffa_pkg::POS_W;

   grffa_pkg::state_type state_ff, state_in;

   logic [grffa_pkg::CSR_DATA_W-1:0] grid_cols_ff, grid_cols_in;
   logic [grffa_pkg::CSR_DATA_W-1:0] grid_rows_ff, grid_rows_in;

   logic [grffa_pkg::OP_W-1:0] op_ff, op_in;
   logic [PW-1:0]              px_ff, px_in, py_ff, py_in;
   logic [SW-1:0]              sx_ff, sx_in, sy_ff, sy_in;

   logic [DW-1:0]       x_ff, x_in;
   logic [MAX_COLS-1:0] mask_ff, mask_in;
   logic [DW-1:0]       iss_row_ff, iss_row_in;
   logic [DW-1:0]       end_ff, end_in;
   logic [SW-1:0]       run_ff, run_in;
   logic                chk_en_ff, chk_en_in;
   logic [DW-1:0]       chk_row_ff, chk_row_in;
   logic                chk_rvld_ff, chk_rvld_in;
   logic [MAX_ROWS-1:0] row_vld_ff, row_vld_in;

   logic          res_ok_ff, res_ok_in;
   logic [PW-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [PW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // datapath helpers
   logic [DW-1:0]       eff_cols, eff_rows;
   logic [DW-1:0]       bx, by;
   logic                start_inb;
   logic [MW-1:0]       ones_w, shifted_w;
   logic                issue;
   logic [MAX_COLS-1:0] ram_rdata, row_cur, row_new;
   logic                row_free, hit, blocked, last_row, col_next_ok, advance;
   logic [DW-1:0]       hit_row;
   logic                single;
   logic                req_accept, slot_free;
   logic                ram_wr_en;

   // effective bounds: registers above the maximum act as the maximum
   assign eff_cols = (DW'(grid_cols_ff) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(grid_cols_ff);
   assign eff_rows = (DW'(grid_rows_ff) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(grid_rows_ff);

   assign single = (op_ff != grffa_pkg::OP_FIND);
   assign bx     = single ? DW'(px_ff) : '0;
   assign by     = single ? DW'(py_ff) : '0;

   assign start_inb = (sx_ff != '0) && (sy_ff != '0)
                      && (bx + DW'(sx_ff) <= eff_cols)
                      && (by + DW'(sy_ff) <= eff_rows);

   assign ones_w    = (MW'(1) << sx_ff) - MW'(1);
   assign shifted_w = ones_w << bx;

   assign issue = ((state_ff == grffa_pkg::ST_SCAN) || (state_ff == grffa_pkg::ST_MODIFY))
                  && (iss_row_ff < end_ff);

   assign row_cur  = chk_rvld_ff ? ram_rdata : '0;
   assign row_free = ((row_cur & mask_ff) == '0);
   assign row_new  = (op_ff == grffa_pkg::OP_FREE) ? (row_cur & ~mask_ff) : (row_cur | mask_ff);

   assign hit      = (state_ff == grffa_pkg::ST_SCAN) && chk_en_ff && row_free
                     && (run_ff + SW'(1) == sy_ff);
   assign blocked  = chk_en_ff && !row_free;
   assign last_row = chk_en_ff && (chk_row_ff + DW'(1) == end_ff);
   assign hit_row  = chk_row_ff + DW'(1) - DW'(sy_ff);
   // column exhausted without a fit
   assign advance     = (state_ff == grffa_pkg::ST_SCAN) && last_row && !hit && !single;
   assign col_next_ok = (x_ff + DW'(1) + DW'(sx_ff) <= eff_cols);

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign ram_wr_en  = (state_ff == grffa_pkg::ST_MODIFY) && chk_en_ff;

   grffa_ram #(
      .WIDTH(MAX_COLS),
      .DEPTH(MAX_ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (chk_row_ff[ROW_AW-1:0]),
      .wr_data (row_new),
      .rd_en   (issue),
      .rd_addr (iss_row_ff[ROW_AW-1:0]),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grffa_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = grffa_pkg::ST_START;
            end
         end
         grffa_pkg::ST_START: begin
            case (op_ff)
               grffa_pkg::OP_FIND, grffa_pkg::OP_PLACE, grffa_pkg::OP_TEST: begin
                  state_in = start_inb ? grffa_pkg::ST_SCAN : grffa_pkg::ST_DONE;
               end
               grffa_pkg::OP_FREE: begin
                  state_in = start_inb ? grffa_pkg::ST_MODIFY : grffa_pkg::ST_DONE;
               end
               default: begin
                  state_in = grffa_pkg::ST_DONE;
               end
            endcase
         end
         grffa_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = (op_ff == grffa_pkg::OP_TEST) ? grffa_pkg::ST_DONE
                                                        : grffa_pkg::ST_MODIFY;
            end else if (blocked && single) begin
               state_in = grffa_pkg::ST_DONE;
            end else if (advance && !col_next_ok) begin
               state_in = grffa_pkg::ST_DONE;
            end
         end
         grffa_pkg::ST_MODIFY: begin
            if (last_row) begin
               state_in = grffa_pkg::ST_DONE;
            end
         end
         grffa_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = grffa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grffa_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and output updates
   always_comb begin
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      x_in         = x_ff;
      mask_in      = mask_ff;
      iss_row_in   = iss_row_ff;
      end_in       = end_ff;
      run_in       = run_ff;
      row_vld_in   = row_vld_ff;
      res_ok_in    = res_ok_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      chk_en_in    = issue && (state_in == state_ff);
      chk_row_in   = iss_row_ff;
      chk_rvld_in  = row_vld_ff[iss_row_ff[ROW_AW-1:0]];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            grffa_pkg::CSR_GRID_COLS: grid_cols_in = csr_wdata;
            grffa_pkg::CSR_GRID_ROWS: grid_rows_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         grffa_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in = req_opcode;
               px_in = req_pos_x;
               py_in = req_pos_y;
               sx_in = req_size_x;
               sy_in = req_size_y;
            end
         end
         grffa_pkg::ST_START: begin
            x_in       = bx;
            mask_in    = shifted_w[MAX_COLS-1:0];
            iss_row_in = by;
            end_in     = single ? (by + DW'(sy_ff)) : eff_rows;
            run_in     = '0;
            res_ok_in  = 1'b0;
            res_x_in   = '0;
            res_y_in   = '0;
            case (op_ff)
               grffa_pkg::OP_CLEAR: begin
                  res_ok_in  = 1'b1;
                  row_vld_in = '0;
               end
               grffa_pkg::OP_FREE: begin
                  res_ok_in = start_inb;
               end
               default: begin
               end
            endcase
         end
         grffa_pkg::ST_SCAN: begin
            if (issue) begin
               iss_row_in = iss_row_ff + DW'(1);
            end
            if (chk_en_ff) begin
               run_in = row_free ? (run_ff + SW'(1)) : '0;
            end
            if (hit) begin
               res_ok_in = 1'b1;
               if (op_ff != grffa_pkg::OP_TEST) begin
                  res_x_in   = x_ff[PW-1:0];
                  res_y_in   = hit_row[PW-1:0];
                  iss_row_in = hit_row;
                  end_in     = chk_row_ff + DW'(1);
               end
            end else if (advance && col_next_ok) begin
               x_in       = x_ff + DW'(1);
               mask_in    = mask_ff << 1;
               iss_row_in = '0;
               run_in     = '0;
            end
         end
         grffa_pkg::ST_MODIFY: begin
            if (issue) begin
               iss_row_in = iss_row_ff + DW'(1);
            end
            if (chk_en_ff) begin
               row_vld_in[chk_row_ff[ROW_AW-1:0]] = 1'b1;
            end
         end
         grffa_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grffa_pkg::ST_IDLE;
         grid_cols_ff <= grffa_pkg::GRID_RESET;
         grid_rows_ff <= grffa_pkg::GRID_RESET;
         row_vld_ff   <= '0;
         chk_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         row_vld_ff   <= row_vld_in;
         chk_en_ff    <= chk_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      x_ff        <= x_in;
      mask_ff     <= mask_in;
      iss_row_ff  <= iss_row_in;
      end_ff      <= end_in;
      run_ff      <= run_in;
      chk_row_ff  <= chk_row_in;
      chk_rvld_ff <= chk_rvld_in;
      res_ok_ff   <= res_ok_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

   assign req_stall   = (state_ff != grffa_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_found_x = rsp_x_ff;
   assign rsp_found_y = rsp_y_ff;

endmodule
